@@ hdl/assert_macros.svh @@
// Assertion macros used by the byte sequencer of the frame builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/ubxfb_pkg.sv @@
// Types and constants shared by the frame builder modules.
package ubxfb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] REG_STUFF_ENABLE  = 3'd0;
    localparam logic [2:0] REG_ESCAPE_BYTE   = 3'd1;
    localparam logic [2:0] REG_WRITE_COMMAND = 3'd2;
    localparam logic [2:0] REG_SYNC_FIRST    = 3'd3;
    localparam logic [2:0] REG_SYNC_SECOND   = 3'd4;

    localparam logic       RST_STUFF_ENABLE  = 1'b1;
    localparam logic [7:0] RST_ESCAPE_BYTE   = 8'h10;
    localparam logic [7:0] RST_WRITE_COMMAND = 8'h00;
    localparam logic [7:0] RST_SYNC_FIRST    = 8'hB5;
    localparam logic [7:0] RST_SYNC_SECOND   = 8'h62;

    localparam logic FUNC_START = 1'b0;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_DATA,
        KIND_ERROR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [15:0] len;
        logic        close;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
    } t_cmd;

    typedef struct packed {
        logic       stuff_enable;
        logic [7:0] escape_byte;
        logic [7:0] write_command;
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } t_cfg;

endpackage

@@ hdl/ubxfb_front.sv @@
// Front end: accepts items, tracks the open frame and the running checksum.
module ubxfb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [7:0]        i_msg_class,
    input  logic [7:0]        i_msg_id,
    input  logic [15:0]       i_payload_length,
    input  logic [7:0]        i_data_byte,
    input  logic              i_full,
    output logic              o_push,
    output ubxfb_pkg::t_cmd   o_cmd
);

    logic [15:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic        r_frame_open, n_frame_open;

    logic [7:0] w_sa1, w_sa2, w_sa3, w_sa4;
    logic [7:0] w_sb2, w_sb3, w_sb4;
    logic [7:0] w_da, w_db;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_sa1 = i_msg_class;
        w_sa2 = w_sa1 + i_msg_id;
        w_sb2 = w_sa1 + w_sa2;
        w_sa3 = w_sa2 + i_payload_length[7:0];
        w_sb3 = w_sb2 + w_sa3;
        w_sa4 = w_sa3 + i_payload_length[15:8];
        w_sb4 = w_sb3 + w_sa4;
        w_da  = r_sum_a + i_data_byte;
        w_db  = r_sum_b + w_da;
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_frame_open = r_frame_open;
        o_cmd.b0     = i_msg_class;
        o_cmd.b1     = i_msg_id;
        o_cmd.len    = i_payload_length;
        o_cmd.kind   = ubxfb_pkg::KIND_ERROR;
        o_cmd.close  = 1'b0;
        o_cmd.ck_a   = w_sa4;
        o_cmd.ck_b   = w_sb4;
        if (i_func == ubxfb_pkg::FUNC_START) begin
            o_cmd.kind   = ubxfb_pkg::KIND_START;
            o_cmd.close  = (i_payload_length == 16'd0);
            n_bytes_left = i_payload_length;
            n_sum_a      = w_sa4;
            n_sum_b      = w_sb4;
            n_frame_open = (i_payload_length != 16'd0);
        end else if (r_frame_open) begin
            o_cmd.kind   = ubxfb_pkg::KIND_DATA;
            o_cmd.b0     = i_data_byte;
            o_cmd.close  = (r_bytes_left == 16'd1);
            o_cmd.ck_a   = w_da;
            o_cmd.ck_b   = w_db;
            n_bytes_left = r_bytes_left - 16'd1;
            n_sum_a      = w_da;
            n_sum_b      = w_db;
            n_frame_open = (r_bytes_left != 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_frame_open <= 1'b0;
        end else if (o_push) begin
            r_bytes_left <= n_bytes_left;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_frame_open <= n_frame_open;
        end
    end

endmodule

@@ hdl/ubxfb_queue.sv @@
// Short command queue between the front end and the byte sequencer.
module ubxfb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ubxfb_pkg::t_cmd   i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ubxfb_pkg::t_cmd   o_head
);

    ubxfb_pkg::t_cmd r_mem [ubxfb_pkg::QUEUE_DEPTH];

    logic [ubxfb_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [ubxfb_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [ubxfb_pkg::QUEUE_CW-1:0] r_count;
    logic                           w_do_pop;

    assign o_full   = (r_count == ubxfb_pkg::QUEUE_CW'(ubxfb_pkg::QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/ubxfb_back.sv @@
// Byte sequencer: walks each queued command and emits the encoded bytes.
`include "assert_macros.svh"

module ubxfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ubxfb_pkg::t_cfg   i_cfg,
    input  logic              i_head_valid,
    input  ubxfb_pkg::t_cmd   i_head,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [7:0]        o_tdata,
    output logic              o_tlast,
    output logic [1:0]        o_tuser
);

    typedef enum logic [3:0] {
        SL_ESC, SL_CMD, SL_SYNC1, SL_SYNC2, SL_CLS, SL_ID,
        SL_LEN_LO, SL_LEN_HI, SL_DATA, SL_CKA, SL_CKB, SL_ERR
    } t_slot;

    t_slot      r_slot, n_slot;
    t_slot      w_slot;
    logic       r_mid;
    logic       r_dup;
    logic [7:0] w_byte;
    logic       w_framed;
    logic       w_end;
    logic       w_dup_needed;
    logic       w_load;

    always_comb begin
        if (r_mid) begin
            w_slot = r_slot;
        end else begin
            unique case (i_head.kind)
                ubxfb_pkg::KIND_START: w_slot = i_cfg.stuff_enable ? SL_ESC : SL_SYNC1;
                ubxfb_pkg::KIND_DATA:  w_slot = SL_DATA;
                default:               w_slot = SL_ERR;
            endcase
        end
    end

    always_comb begin
        w_framed = 1'b1;
        w_end    = 1'b0;
        n_slot   = w_slot;
        unique case (w_slot)
            SL_ESC: begin
                w_byte   = i_cfg.escape_byte;
                w_framed = 1'b0;
                n_slot   = SL_CMD;
            end
            SL_CMD: begin
                w_byte   = i_cfg.write_command;
                w_framed = 1'b0;
                n_slot   = SL_SYNC1;
            end
            SL_SYNC1: begin
                w_byte = i_cfg.sync_first;
                n_slot = SL_SYNC2;
            end
            SL_SYNC2: begin
                w_byte = i_cfg.sync_second;
                n_slot = SL_CLS;
            end
            SL_CLS: begin
                w_byte = i_head.b0;
                n_slot = SL_ID;
            end
            SL_ID: begin
                w_byte = i_head.b1;
                n_slot = SL_LEN_LO;
            end
            SL_LEN_LO: begin
                w_byte = i_head.len[7:0];
                n_slot = SL_LEN_HI;
            end
            SL_LEN_HI: begin
                w_byte = i_head.len[15:8];
                n_slot = SL_CKA;
                w_end  = !i_head.close;
            end
            SL_DATA: begin
                w_byte = i_head.b0;
                n_slot = SL_CKA;
                w_end  = !i_head.close;
            end
            SL_CKA: begin
                w_byte = i_head.ck_a;
                n_slot = SL_CKB;
            end
            SL_CKB: begin
                w_byte = i_head.ck_b;
                w_end  = 1'b1;
            end
            default: begin
                w_byte   = 8'h00;
                w_framed = 1'b0;
                w_end    = 1'b1;
            end
        endcase
    end

    assign w_dup_needed = i_cfg.stuff_enable && w_framed && !r_dup
                          && (w_byte == i_cfg.escape_byte);
    assign w_load       = i_head_valid && (!o_tvalid || i_tready);
    assign o_pop        = w_load && w_end && !w_dup_needed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= SL_ESC;
            r_mid    <= 1'b0;
            r_dup    <= 1'b0;
            o_tvalid <= 1'b0;
        end else begin
            if (w_load) begin
                o_tvalid   <= 1'b1;
                o_tdata    <= w_byte;
                o_tlast    <= w_end && !w_dup_needed;
                o_tuser[0] <= (w_slot == SL_CKB) && !w_dup_needed;
                o_tuser[1] <= (w_slot == SL_ERR);
                if (w_dup_needed) begin
                    r_dup  <= 1'b1;
                    r_mid  <= 1'b1;
                    r_slot <= w_slot;
                end else begin
                    r_dup  <= 1'b0;
                    r_mid  <= !w_end;
                    r_slot <= n_slot;
                end
            end else if (i_tready) begin
                o_tvalid <= 1'b0;
            end
        end
    end

    `ASSERT_IMP(a_done_ends_item, i_clk, i_rst_n, o_tvalid && o_tuser[0], o_tlast)
    `ASSERT_IMP(a_error_alone, i_clk, i_rst_n, o_tvalid && o_tuser[1], o_tlast && !o_tuser[0])
    `ASSERT_IMP(a_error_zero, i_clk, i_rst_n, o_tvalid && o_tuser[1], o_tdata == 8'h00)
    `ASSERT_NXT(a_dup_repeats, i_clk, i_rst_n, w_load && w_dup_needed, r_dup && r_mid)
    `ASSERT_NXT(a_dup_byte, i_clk, i_rst_n, w_load && w_dup_needed, o_tdata == $past(w_byte))

endmodule

@@ hdl/ubx_frame_builder_with_stuffing_top.sv @@
// Top level of the frame builder: configuration registers, front end, queue, sequencer.
// Each accepted item is written into the queue before the sequencer registers its bytes.
// The sequencer emits one byte per cycle unless stalled; an item yields 1 to 18 bytes:
// 1 for a non-closing payload byte, 2 when it is doubled, up to 18 for a stuffed start.
// The front end takes one item per cycle while the four-entry queue has room.
// Reset restores the register defaults, closes any frame and empties the queue.
module ubx_frame_builder_with_stuffing_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // msg_class, msg_id, payload_length, data_byte
    input  logic [39:0] s_axis_tdata,
    // func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // frame_done, item_error
    output logic [1:0]  m_axis_tuser
);

    ubxfb_pkg::t_cfg r_cfg;
    ubxfb_pkg::t_cmd w_push_cmd;
    ubxfb_pkg::t_cmd w_head;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_head_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stuff_enable  <= ubxfb_pkg::RST_STUFF_ENABLE;
            r_cfg.escape_byte   <= ubxfb_pkg::RST_ESCAPE_BYTE;
            r_cfg.write_command <= ubxfb_pkg::RST_WRITE_COMMAND;
            r_cfg.sync_first    <= ubxfb_pkg::RST_SYNC_FIRST;
            r_cfg.sync_second   <= ubxfb_pkg::RST_SYNC_SECOND;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ubxfb_pkg::REG_STUFF_ENABLE:  r_cfg.stuff_enable  <= i_cfg_data[0];
                ubxfb_pkg::REG_ESCAPE_BYTE:   r_cfg.escape_byte   <= i_cfg_data;
                ubxfb_pkg::REG_WRITE_COMMAND: r_cfg.write_command <= i_cfg_data;
                ubxfb_pkg::REG_SYNC_FIRST:    r_cfg.sync_first    <= i_cfg_data;
                ubxfb_pkg::REG_SYNC_SECOND:   r_cfg.sync_second   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ubxfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_func           (s_axis_tuser),
        .i_msg_class      (s_axis_tdata[7:0]),
        .i_msg_id         (s_axis_tdata[15:8]),
        .i_payload_length (s_axis_tdata[31:16]),
        .i_data_byte      (s_axis_tdata[39:32]),
        .i_full           (w_full),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd)
    );

    ubxfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    ubxfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast),
        .o_tuser      (m_axis_tuser)
    );

endmodule
